### design/wsof_pkg.sv
// Shared types, constants and command/status bundles for the windowed
// statistics outlier filter. No dependencies.
package wsof_pkg;

  localparam int unsigned DefaultWindowDepth = 128;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned ThreshW   = 8;
  localparam logic [ThreshW-1:0] ThresholdReset = 8'd32;  // 2.0 in Q4.4

  localparam logic CmdPush   = 1'b0;
  localparam logic CmdRemove = 1'b1;

  typedef struct packed {
    logic                      cmd;
    logic signed [SampleW-1:0] sample;
  } wsof_in_t;

  typedef struct packed {
    logic signed [31:0] mean_out;
    logic [47:0]        variance_out;
    logic [23:0]        stddev_out;
    logic [7:0]         fill_out;
  } wsof_out_t;

  typedef enum logic [4:0] {
    StIdle,
    StPush,
    StRmInit,
    StRmRead,
    StRmTest,
    StRbInit,
    StRbRead,
    StRbDiff,
    StRbDiv,
    StRbD2,
    StRbMul,
    StRbAcc,
    StVar,
    StVarDiv,
    StSqrtStart,
    StSqrtWait,
    StFinish
  } wsof_state_e;

  typedef struct packed {
    logic latch_in;
    logic push_wr;
    logic rm_init;
    logic rm_test;
    logic rm_done;
    logic rb_init;
    logic div_entry;
    logic mean_upd;
    logic d2_load;
    logic mul_load;
    logic acc;
    logic var_start;
    logic var_zero;
    logic var_load;
    logic sqrt_start;
    logic sd_load;
    logic out_load;
  } wsof_cmd_t;

  typedef struct packed {
    logic idx_lt_fill;
    logic fill_lt2;
    logic div_busy;
    logic sqrt_busy;
  } wsof_sts_t;

endpackage

### design/wsof_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Short mode divides a 32-bit value, long mode a 64-bit one.
// Depends on wsof_pkg.
module wsof_div import wsof_pkg::*; #(
  parameter int unsigned CW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          short_i,
  input  logic [63:0]   dividend_i,
  input  logic [CW-1:0] divisor_i,
  output logic          busy_o,
  output logic [63:0]   quot_o
);

  logic [63:0]   dvd_q;
  logic [CW-1:0] rem_q;
  logic [CW-1:0] div_q;
  logic [6:0]    cnt_q;
  logic          busy_q;

  logic [CW:0] rem_sh;
  logic [CW:0] rem_nx;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, dvd_q[63]};
    ge     = rem_sh >= {1'b0, div_q};
    rem_nx = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= short_i ? 7'd32 : 7'd64;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= short_i ? {dividend_i[31:0], 32'd0} : dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[62:0], ge};
      rem_q <= rem_nx[CW-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q;

endmodule

### design/wsof_sqrt.sv
// Integer square root of a 48-bit value, two radicand bits per cycle.
// Depends on wsof_pkg.
module wsof_sqrt import wsof_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] rad_i,
  output logic        busy_o,
  output logic [23:0] root_o
);

  logic [47:0] rad_q;
  logic [25:0] rem_q;
  logic [23:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q;

  logic [27:0] rem_sh;
  logic [27:0] trial;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q, rad_q[47:46]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 5'd24;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[45:0], 2'b00};
      rem_q  <= ge ? 26'(rem_sh - trial) : rem_sh[25:0];
      root_q <= {root_q[22:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

### design/wsof_ctrl.sv
// Command sequencer: walks push / remove / rebuild / variance / root steps
// and owns the channel handshakes. Depends on wsof_pkg.
module wsof_ctrl import wsof_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_cmd_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  wsof_sts_t sts_i,
  output wsof_cmd_t cmd_o
);

  wsof_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d = (in_cmd_i == CmdRemove) ? StRmInit : StPush;
        end
      end
      StPush: begin
        cmd_o.push_wr = 1'b1;
        state_d = StRbInit;
      end
      StRmInit: begin
        cmd_o.rm_init = 1'b1;
        state_d = StRmRead;
      end
      StRmRead: begin
        if (sts_i.idx_lt_fill) begin
          state_d = StRmTest;
        end else begin
          cmd_o.rm_done = 1'b1;
          state_d = StRbInit;
        end
      end
      StRmTest: begin
        cmd_o.rm_test = 1'b1;
        state_d = StRmRead;
      end
      StRbInit: begin
        cmd_o.rb_init = 1'b1;
        state_d = StRbRead;
      end
      StRbRead: begin
        state_d = sts_i.idx_lt_fill ? StRbDiff : StVar;
      end
      StRbDiff: begin
        cmd_o.div_entry = 1'b1;
        state_d = StRbDiv;
      end
      StRbDiv: begin
        if (!sts_i.div_busy) begin
          cmd_o.mean_upd = 1'b1;
          state_d = StRbD2;
        end
      end
      StRbD2: begin
        cmd_o.d2_load = 1'b1;
        state_d = StRbMul;
      end
      StRbMul: begin
        cmd_o.mul_load = 1'b1;
        state_d = StRbAcc;
      end
      StRbAcc: begin
        cmd_o.acc = 1'b1;
        state_d = StRbRead;
      end
      StVar: begin
        if (sts_i.fill_lt2) begin
          cmd_o.var_zero = 1'b1;
          state_d = StSqrtStart;
        end else begin
          cmd_o.var_start = 1'b1;
          state_d = StVarDiv;
        end
      end
      StVarDiv: begin
        if (!sts_i.div_busy) begin
          cmd_o.var_load = 1'b1;
          state_d = StSqrtStart;
        end
      end
      StSqrtStart: begin
        cmd_o.sqrt_start = 1'b1;
        state_d = StSqrtWait;
      end
      StSqrtWait: begin
        if (!sts_i.sqrt_busy) begin
          cmd_o.sd_load = 1'b1;
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/wsof_dp.sv
// Datapath: circular sample store, Welford accumulators, outlier compare,
// shared divider and square root unit. Depends on wsof_pkg, wsof_div,
// wsof_sqrt.
module wsof_dp import wsof_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = DefaultWindowDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wsof_cmd_t          cmd_i,
  output wsof_sts_t          sts_o,
  input  wsof_in_t           in_data_i,
  input  logic               cfg_valid_i,
  input  logic [ThreshW-1:0] cfg_data_i,
  output wsof_out_t          out_data_o
);

  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [AW:0] DepthA = (AW+1)'(WINDOW_DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(WINDOW_DEPTH);

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DepthA) begin
      sum = sum - DepthA;
    end
    return sum[AW-1:0];
  endfunction

  logic [SampleW-1:0] mem [WINDOW_DEPTH];
  logic [SampleW-1:0] rd_data_q;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [SampleW-1:0] wr_data;
  logic               wr_en;

  logic [SampleW-1:0] samp_q;
  logic [ThreshW-1:0] thr_q;
  logic [CW-1:0]      fill_q, idx_q, kept_q;
  logic [AW-1:0]      head_q;
  logic signed [31:0] mean_q;
  logic [63:0]        sum_q;
  logic [47:0]        var_q;
  logic [23:0]        sd_q;
  logic [35:0]        limit_q;
  logic [SampleW-1:0] x_q;
  logic               dneg_q;
  logic [31:0]        absd_q, absd2_q;
  logic [63:0]        prod_q;
  wsof_out_t          out_q;

  logic signed [31:0] x_rd, x_ent;
  logic signed [32:0] d_w, d2_w, mean_w;
  logic [32:0]        negd, negd2;
  logic [31:0]        absd_w, absd2_w;
  logic               keep;
  logic [31:0]        limit_w;
  logic [31:0]        fill_w;

  logic          div_start, div_short, div_busy;
  logic [63:0]   div_dvd, div_quot;
  logic [CW-1:0] div_dsr;
  logic          sqrt_busy;
  logic [23:0]   sqrt_root;

  // distances of the freshly read and the entered sample from the current mean, keep test, mean update and limit
  always_comb begin
    x_rd   = {rd_data_q, 16'd0};
    d_w    = {x_rd[31], x_rd} - {mean_q[31], mean_q};
    negd   = -d_w;
    absd_w = d_w[32] ? negd[31:0] : d_w[31:0];
    keep   = {4'd0, absd_w} <= limit_q;
    x_ent  = {x_q, 16'd0};
    d2_w   = {x_ent[31], x_ent} - {mean_q[31], mean_q};
    negd2  = -d2_w;
    absd2_w = d2_w[32] ? negd2[31:0] : d2_w[31:0];
    mean_w = dneg_q ? ({mean_q[31], mean_q} - {1'b0, div_quot[31:0]})
                    : ({mean_q[31], mean_q} + {1'b0, div_quot[31:0]});
    limit_w = 32'(thr_q) * 32'(sd_q);
    fill_w  = 32'(fill_q);
  end

  always_comb begin
    rd_addr = wrap_add(head_q, idx_q[AW-1:0]);
    wr_en   = 1'b0;
    wr_addr = wrap_add(head_q, kept_q[AW-1:0]);
    wr_data = rd_data_q;
    if (cmd_i.push_wr) begin
      wr_en   = 1'b1;
      wr_data = samp_q;
      wr_addr = (fill_q < DepthC) ? wrap_add(head_q, fill_q[AW-1:0]) : head_q;
    end else if (cmd_i.rm_test && keep) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThresholdReset;
      fill_q <= '0;
      head_q <= '0;
      idx_q  <= '0;
      kept_q <= '0;
      mean_q <= '0;
      sum_q  <= '0;
      var_q  <= '0;
      sd_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      if (cmd_i.push_wr) begin
        if (fill_q < DepthC) begin
          fill_q <= fill_q + CW'(1);
        end else begin
          head_q <= wrap_add(head_q, AW'(1));
        end
      end
      if (cmd_i.rm_init || cmd_i.rb_init) begin
        idx_q  <= '0;
        kept_q <= '0;
      end
      if (cmd_i.rm_test) begin
        idx_q <= idx_q + CW'(1);
        if (keep) begin
          kept_q <= kept_q + CW'(1);
        end
      end
      if (cmd_i.rm_done) begin
        fill_q <= kept_q;
      end
      if (cmd_i.rb_init) begin
        mean_q <= '0;
        sum_q  <= '0;
      end
      if (cmd_i.mean_upd) begin
        mean_q <= mean_w[31:0];
      end
      if (cmd_i.acc) begin
        sum_q <= sum_q + {16'd0, prod_q[63:16]};
        idx_q <= idx_q + CW'(1);
      end
      if (cmd_i.var_zero) begin
        var_q <= '0;
      end
      if (cmd_i.var_load) begin
        var_q <= (|div_quot[63:48]) ? '1 : div_quot[47:0];
      end
      if (cmd_i.sd_load) begin
        sd_q <= sqrt_root;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      samp_q <= in_data_i.sample;
    end
    if (cmd_i.rm_init) begin
      limit_q <= {limit_w, 4'd0};
    end
    if (cmd_i.div_entry) begin
      x_q    <= rd_data_q;
      dneg_q <= d_w[32];
      absd_q <= absd_w;
    end
    if (cmd_i.d2_load) begin
      absd2_q <= absd2_w;
    end
    if (cmd_i.mul_load) begin
      prod_q <= 64'(absd_q) * 64'(absd2_q);
    end
    if (cmd_i.out_load) begin
      out_q.mean_out     <= mean_q;
      out_q.variance_out <= var_q;
      out_q.stddev_out   <= sd_q;
      out_q.fill_out     <= fill_w[7:0];
    end
  end

  always_comb begin
    div_start = cmd_i.div_entry || cmd_i.var_start;
    div_short = cmd_i.div_entry;
    div_dvd   = cmd_i.div_entry ? {32'd0, absd_w} : sum_q;
    div_dsr   = cmd_i.div_entry ? (idx_q + CW'(1)) : (fill_q - CW'(1));
  end

  wsof_div #(.CW(CW)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .short_i   (div_short),
    .dividend_i(div_dvd),
    .divisor_i (div_dsr),
    .busy_o    (div_busy),
    .quot_o    (div_quot)
  );

  wsof_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.sqrt_start),
    .rad_i  (var_q),
    .busy_o (sqrt_busy),
    .root_o (sqrt_root)
  );

  always_comb begin
    sts_o.idx_lt_fill = idx_q < fill_q;
    sts_o.fill_lt2    = fill_q < CW'(2);
    sts_o.div_busy    = div_busy;
    sts_o.sqrt_busy   = sqrt_busy;
  end

  assign out_data_o = out_q;

endmodule

### design/windowed_stats_outlier_filter.sv
// Windowed mean / variance with outlier removal. One request at a time: a
// remove first scans the held samples, then every request makes one
// 32-step pass of the shared radix-2 divider per held sample (plus read,
// multiply and accumulate), then the 64-bit variance divide (skipped below
// two samples) and the 24-step square root. Input stall is low only while
// idle; a finished result sits in the output register and does not block
// acceptance of the next request, but that request cannot finish until the
// old result is taken. No clearing pass after reset. Config writes are
// always ready.
// Depends on wsof_pkg, wsof_ctrl, wsof_dp.
module windowed_stats_outlier_filter import wsof_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = DefaultWindowDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wsof_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wsof_out_t          out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [ThreshW-1:0] cfg_data_i
);

  wsof_cmd_t cmd;
  wsof_sts_t sts;

  assign cfg_ready_o = 1'b1;

  wsof_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_data_i.cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wsof_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

### design/wsof_checker.sv
// Port-level checks for the outlier filter, bound to the top level.
// Depends on wsof_pkg and windowed_stats_outlier_filter.
module wsof_checker import wsof_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = DefaultWindowDepth
) (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input wsof_out_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while busy");

  a_small_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (WINDOW_DEPTH < 256) && (out_data_o.fill_out < 8'd2)
      |-> out_data_o.variance_out == '0 && out_data_o.stddev_out == '0)
    else $error("nonzero spread below two samples");

  a_empty_mean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (WINDOW_DEPTH < 256) && (out_data_o.fill_out == 8'd0)
      |-> out_data_o.mean_out == '0)
    else $error("nonzero mean on empty window");

  a_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.variance_out == '0 |-> out_data_o.stddev_out == '0)
    else $error("root of zero variance not zero");

endmodule

bind windowed_stats_outlier_filter wsof_checker #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_wsof_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
